@@ rtl/core/ids_pkg.sv @@
// ----------------------------------------------------------------------------
// ids_pkg
// Types, codes and the letter-range table shared by the instance dispatch
// selector.
// ----------------------------------------------------------------------------
package ids_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_FINISH
    } ids_state_t;

    // request kinds carried in s_tuser
    localparam logic [1:0] OP_SELECT  = 2'd0;
    localparam logic [1:0] OP_AVAIL   = 2'd1;
    localparam logic [1:0] OP_ENTRIES = 2'd2;

    // dispatch policies
    localparam logic [1:0] POL_RR    = 2'd0;
    localparam logic [1:0] POL_LEAST = 2'd1;
    localparam logic [1:0] POL_KEY   = 2'd2;

    // key letters
    localparam logic [7:0] UPPER_FIRST  = 8'd65;
    localparam logic [7:0] UPPER_LAST   = 8'd90;
    localparam logic [7:0] LETTER_FIRST = 8'd97;
    localparam logic [7:0] LETTER_LAST  = 8'd122;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // letters per available instance: ceil(26 / n)
    function automatic logic [4:0] letters_per(input logic [4:0] n);
        logic [4:0] per;
        case (n) inside
            5'd1:                        per = 5'd26;
            5'd2:                        per = 5'd13;
            5'd3:                        per = 5'd9;
            5'd4:                        per = 5'd7;
            5'd5:                        per = 5'd6;
            5'd6:                        per = 5'd5;
            5'd7, 5'd8:                  per = 5'd4;
            5'd9, 5'd10, 5'd11, 5'd12:   per = 5'd3;
            5'd0:                        per = 5'd26;
            default: begin
                if (n <= 5'd25) begin
                    per = 5'd2;
                end else begin
                    per = 5'd1;
                end
            end
        endcase
        return per;
    endfunction

endpackage

@@ rtl/core/instance_dispatch_selector.sv @@
// ----------------------------------------------------------------------------
// instance_dispatch_selector
// Picks a storage instance per select request under round-robin, least-used
// or key-range policy, and takes availability and entry-count updates.
//
//  channel   | direction | handshake           | word
//  ----------+-----------+---------------------+------------------------------
//  s_        | in        | s_tvalid / s_tready | tuser op, tdata key/target/..
//  m_        | out       | m_tvalid / m_tready | tuser granted, tdata index
//  cfg_      | in        | cfg_valid/cfg_ready | policy_mode
//
// A select word walks the instances one per cycle through a single compare
// unit: round robin in one pick pass, least used and key range in a first
// counting or minimum pass, then a pick pass where one is needed. Synchronous
// reset clears control and output state; the scan working registers are not.
// The result sits in an output register; a new word is taken while it waits,
// and a finished word holds in the last step until that register is free.
// ----------------------------------------------------------------------------
module instance_dispatch_selector
    import ids_pkg::*;
#(
    parameter int INSTANCES  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,      // policy_mode
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,       // op
    input  logic [31:0] s_tdata,       // key_first_char, target_index,
                                       // avail_value, entries_value, zero pad
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [0:0]  m_tuser,       // granted
    output logic [7:0]  m_tdata        // chosen_index, zero pad
);

    localparam int IDX_W = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
    localparam int CNT_W = $clog2(INSTANCES + 1);
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(INSTANCES - 1);
    localparam logic [CNT_W-1:0] STEP_MAX = CNT_W'(INSTANCES - 1);

    // input word fields
    logic [7:0]  in_key;
    logic [2:0]  in_target;
    logic        in_avail;
    logic [15:0] in_entries;

    assign in_key     = s_tdata[7:0];
    assign in_target  = s_tdata[10:8];
    assign in_avail   = s_tdata[11];
    assign in_entries = s_tdata[27:12];

    ids_state_t state_reg, state_next;

    logic [1:0]            policy_reg;
    logic [INSTANCES-1:0]  avail_reg,  avail_next;
    logic [COUNT_BITS-1:0] used_reg [INSTANCES];
    logic                  used_we;
    logic [IDX_W-1:0]      used_waddr;
    logic [COUNT_BITS-1:0] used_wdata;
    logic [IDX_W-1:0]      last_reg,   last_next;
    logic                  last_valid_reg, last_valid_next;

    logic [IDX_W-1:0]      idx_reg,    idx_next;
    logic [CNT_W-1:0]      step_reg,   step_next;
    logic                  found_reg,  found_next;
    logic                  tie_reg,    tie_next;
    logic [IDX_W-1:0]      best_reg,   best_next;
    logic [COUNT_BITS-1:0] min_reg,    min_next;
    logic [CNT_W-1:0]      num_reg,    num_next;
    logic [5:0]            acc_reg,    acc_next;
    logic [4:0]            letter_reg, letter_next;
    logic                  letter_ok_reg, letter_ok_next;
    logic                  key_pass_reg,  key_pass_next;
    logic                  grant_reg,  grant_next;
    logic [IDX_W-1:0]      pick_reg,   pick_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_grant_reg, out_grant_next;
    logic [2:0]            out_idx_reg,   out_idx_next;

    // shared scan datapath
    logic                  accept;
    logic                  cur_av;
    logic [COUNT_BITS-1:0] cur_used;
    logic                  last_step;
    logic [IDX_W-1:0]      idx_wrap;
    logic [IDX_W-1:0]      start_idx;
    logic                  target_ok;
    logic [IDX_W-1:0]      target_idx;
    logic [7:0]            key_fold;
    logic                  lu_take;
    logic                  lu_tie;
    logic                  lu_found_nx;
    logic                  lu_tie_nx;
    logic [IDX_W-1:0]      lu_best_nx;
    logic [CNT_W-1:0]      num_nx;
    logic [4:0]            per;
    logic [5:0]            acc_sum;
    logic                  key_hit;
    logic                  out_free;

    assign accept    = s_tvalid && s_tready;
    assign cur_av    = avail_reg[idx_reg];
    assign cur_used  = used_reg[idx_reg];
    assign last_step = (step_reg == STEP_MAX);
    assign idx_wrap  = (idx_reg == IDX_MAX) ? '0 : idx_reg + 1'b1;
    assign start_idx = !last_valid_reg ? '0
                     : ((last_reg == IDX_MAX) ? '0 : last_reg + 1'b1);

    assign target_ok  = (32'(in_target) < INSTANCES);
    assign target_idx = IDX_W'(in_target);

    // fold upper case before the range check
    assign key_fold = (in_key >= UPPER_FIRST && in_key <= UPPER_LAST)
                    ? in_key + CASE_OFFSET : in_key;

    // least-used compare
    assign lu_take     = cur_av && (!found_reg || cur_used < min_reg);
    assign lu_tie      = cur_av && found_reg && (cur_used == min_reg);
    assign lu_found_nx = found_reg || cur_av;
    assign lu_tie_nx   = lu_take ? 1'b0 : (tie_reg || lu_tie);
    assign lu_best_nx  = lu_take ? idx_reg : best_reg;

    // key range: instance covers letters [acc, acc + per)
    assign num_nx  = num_reg + CNT_W'(cur_av);
    assign per     = letters_per(5'(num_reg));
    assign acc_sum = acc_reg + {1'b0, per};
    assign key_hit = cur_av && ({1'b0, letter_reg} < acc_sum);

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_SELECT) begin
                        case (policy_reg) inside
                            POL_RR:             state_next = ST_SCAN_B;
                            POL_LEAST, POL_KEY: state_next = ST_SCAN_A;
                            default:            state_next = ST_FINISH;
                        endcase
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN_A: begin
                if (last_step) begin
                    if (policy_reg == POL_LEAST) begin
                        state_next = (lu_found_nx && lu_tie_nx) ? ST_SCAN_B : ST_FINISH;
                    end else begin
                        state_next = (num_nx != '0 && letter_ok_reg) ? ST_SCAN_B
                                                                     : ST_FINISH;
                    end
                end
            end
            ST_SCAN_B: begin
                if (key_pass_reg ? key_hit : cur_av) begin
                    state_next = ST_FINISH;
                end else if (last_step) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        avail_next      = avail_reg;
        used_we         = 1'b0;
        used_waddr      = target_idx;
        used_wdata      = COUNT_BITS'({16'd0, in_entries});
        last_next       = last_reg;
        last_valid_next = last_valid_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        tie_next        = tie_reg;
        best_next       = best_reg;
        min_next        = min_reg;
        num_next        = num_reg;
        acc_next        = acc_reg;
        letter_next     = letter_reg;
        letter_ok_next  = letter_ok_reg;
        key_pass_next   = key_pass_reg;
        grant_next      = grant_reg;
        pick_next       = pick_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_grant_next  = out_grant_reg;
        out_idx_next    = out_idx_reg;

        s_tready  = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    grant_next     = 1'b0;
                    pick_next      = '0;
                    step_next      = '0;
                    found_next     = 1'b0;
                    tie_next       = 1'b0;
                    num_next       = '0;
                    acc_next       = '0;
                    key_pass_next  = 1'b0;
                    letter_next    = 5'(key_fold - LETTER_FIRST);
                    letter_ok_next = (key_fold >= LETTER_FIRST)
                                  && (key_fold <= LETTER_LAST);
                    idx_next       = (policy_reg == POL_RR) ? start_idx : '0;
                    case (s_tuser)
                        OP_AVAIL: begin
                            if (target_ok) begin
                                avail_next[target_idx] = in_avail;
                            end
                        end
                        OP_ENTRIES: begin
                            used_we = target_ok;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN_A: begin
                if (policy_reg == POL_LEAST) begin
                    found_next = lu_found_nx;
                    tie_next   = lu_tie_nx;
                    best_next  = lu_best_nx;
                    if (lu_take) begin
                        min_next = cur_used;
                    end
                end else begin
                    num_next = num_nx;
                end
                if (last_step) begin
                    step_next = '0;
                    if (policy_reg == POL_LEAST) begin
                        idx_next = start_idx;
                        if (lu_found_nx && !lu_tie_nx) begin
                            grant_next = 1'b1;
                            pick_next  = lu_best_nx;
                        end
                    end else begin
                        idx_next      = '0;
                        key_pass_next = 1'b1;
                    end
                end else begin
                    idx_next  = idx_wrap;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SCAN_B: begin
                if (key_pass_reg ? key_hit : cur_av) begin
                    grant_next = 1'b1;
                    pick_next  = idx_reg;
                end else begin
                    if (cur_av) begin
                        acc_next = acc_sum;
                    end
                    idx_next  = idx_wrap;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_grant_next = grant_reg;
                    out_idx_next   = 3'(pick_reg);
                    if (grant_reg) begin
                        last_next       = pick_reg;
                        last_valid_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_grant_reg;
    assign m_tdata  = {5'd0, out_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            policy_reg     <= POL_RR;
            avail_reg      <= '0;
            for (int i = 0; i < INSTANCES; i++) begin
                used_reg[i] <= '0;
            end
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_grant_reg  <= 1'b0;
            out_idx_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready) begin
                policy_reg <= cfg_data;
            end
            avail_reg      <= avail_next;
            if (used_we) begin
                used_reg[used_waddr] <= used_wdata;
            end
            last_reg       <= last_next;
            last_valid_reg <= last_valid_next;
            out_valid_reg  <= out_valid_next;
            out_grant_reg  <= out_grant_next;
            out_idx_reg    <= out_idx_next;
        end
    end

    // scan working registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        found_reg     <= found_next;
        tie_reg       <= tie_next;
        best_reg      <= best_next;
        min_reg       <= min_next;
        num_reg       <= num_next;
        acc_reg       <= acc_next;
        letter_reg    <= letter_next;
        letter_ok_reg <= letter_ok_next;
        key_pass_reg  <= key_pass_next;
        grant_reg     <= grant_next;
        pick_reg      <= pick_next;
    end

endmodule
